/* rtl/lpt_pkg.sv */
// Shared types, constants and helper functions of the leg-module PD torque block.
`default_nettype none

package lpt_pkg;

  // Pi and two pi with 30 fraction bits, rounded to the working precision below.
  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // Magnitude width of the wrapped position error before reduction.
  localparam int unsigned MAG_W = 33;

  // Configuration register indexes.
  localparam logic [2:0] REG_SAMPLE_RATE  = 3'd0;
  localparam logic [2:0] REG_DEFAULT_P    = 3'd1;
  localparam logic [2:0] REG_DEFAULT_D    = 3'd2;
  localparam logic [2:0] REG_THETA_OFFSET = 3'd3;

  // Step controls that the sequencer hands to both lanes and the merge stage.
  typedef struct packed {
    logic load;
    logic q_mul;
    logic r_mul;
    logic r_fold;
    logic v_mul;
    logic v_sat;
    logic d_mul;
    logic fix;
    logic p_mul;
    logic sum;
    logic capture;
  } lane_ctrl_t;

  // Round a constant with 30 fraction bits to frac fraction bits.
  function automatic logic [MAG_W-1:0] round_q30(input logic [63:0] v, input int frac);
    logic [63:0] r;
    r = (v + (64'd1 << (29 - frac))) >> (30 - frac);
    return r[MAG_W-1:0];
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/lpt_lane.sv */
// One motor lane: velocity, wrapped position error, PD products and torque sum.
`default_nettype none

module lpt_lane import lpt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  lane_ctrl_t         ctrl_i,
  input  logic signed [31:0] angle_i,
  input  logic signed [31:0] prev_i,
  input  logic signed [33:0] ref_i,
  input  logic        [23:0] kp_i,
  input  logic        [23:0] kd_i,
  input  logic signed [31:0] ff_i,
  input  logic        [15:0] rate_i,
  output logic signed [31:0] torque_o,
  output logic signed [31:0] velocity_o
);

  localparam logic [MAG_W-1:0] PI_Q     = round_q30(PI_Q30, FRAC_BITS);
  localparam logic [MAG_W-1:0] TWO_PI_Q = round_q30(TWO_PI_Q30, FRAC_BITS);
  // Reciprocal of two pi scaled by 2^MAG_W; the quotient estimate is at most one low.
  localparam logic [MAG_W-1:0] RECIP    = MAG_W'((64'd1 << MAG_W) / 64'(TWO_PI_Q));
  localparam int unsigned      ERR_W    = FRAC_BITS + 4;
  localparam int unsigned      P_W      = 25 + ERR_W;
  localparam logic signed [63:0] HALF   = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [34:0]      x;
  logic        [34:0]      x_abs;
  logic        [2*MAG_W-1:0] qprod;
  logic        [MAG_W-1:0] rprod;
  logic        [MAG_W-1:0] mod_val;
  logic signed [ERR_W-1:0] err_d;
  logic signed [32:0]      neg_vel;
  logic signed [63:0]      p_term;
  logic signed [63:0]      sum_d;

  logic                    neg_q;
  logic        [MAG_W-1:0] mag_q;
  logic        [MAG_W-1:0] quot_q;
  logic        [MAG_W-1:0] rem_q;
  logic signed [32:0]      diff_q;
  logic        [23:0]      kp_q;
  logic        [23:0]      kd_q;
  logic signed [31:0]      ff_q;
  logic signed [49:0]      vprod_q;
  logic signed [31:0]      vel_q;
  logic signed [57:0]      dprod_q;
  logic signed [63:0]      dterm_q;
  logic signed [ERR_W-1:0] err_q;
  logic signed [P_W-1:0]   pprod_q;
  logic signed [31:0]      torque_q;

  // Unwrapped error plus half a turn, split into sign and magnitude.
  assign x     = 35'(ref_i) - 35'(angle_i) + $signed({2'b00, PI_Q});
  assign x_abs = x[34] ? 35'(-x) : 35'(x);

  // Quotient estimate by the reciprocal, and the quotient times two pi.
  assign qprod = mag_q * RECIP;
  assign rprod = quot_q * TWO_PI_Q;

  // Non-negative remainder, then shifted back by half a turn.
  always_comb begin
    if (neg_q && (rem_q != '0)) begin
      mod_val = TWO_PI_Q - rem_q;
    end else if (neg_q) begin
      mod_val = '0;
    end else begin
      mod_val = rem_q;
    end
    err_d = ERR_W'($signed({1'b0, mod_val}) - $signed({1'b0, PI_Q}));
  end

  assign neg_vel = -33'(vel_q);
  assign p_term  = (64'(pprod_q) + HALF) >>> FRAC_BITS;
  assign sum_d   = p_term + dterm_q + 64'(ff_q);

  // Datapath registers, stepped by the shared sequencer.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      neg_q  <= x[34];
      mag_q  <= x_abs[MAG_W-1:0];
      diff_q <= 33'(angle_i) - 33'(prev_i);
      kp_q   <= kp_i;
      kd_q   <= kd_i;
      ff_q   <= ff_i;
    end
    if (ctrl_i.q_mul) begin
      quot_q <= qprod[2*MAG_W-1:MAG_W];
    end
    // The estimated remainder lies below two turns; one subtraction finishes it.
    if (ctrl_i.r_mul) begin
      rem_q <= mag_q - rprod;
    end else if (ctrl_i.r_fold && (rem_q >= TWO_PI_Q)) begin
      rem_q <= rem_q - TWO_PI_Q;
    end
    if (ctrl_i.v_mul) begin
      vprod_q <= diff_q * $signed({1'b0, rate_i});
    end
    if (ctrl_i.v_sat) begin
      vel_q <= sat32(64'(vprod_q));
    end
    if (ctrl_i.d_mul) begin
      dprod_q <= $signed({1'b0, kd_q}) * neg_vel;
    end
    if (ctrl_i.fix) begin
      err_q   <= err_d;
      dterm_q <= (64'(dprod_q) + HALF) >>> FRAC_BITS;
    end
    if (ctrl_i.p_mul) begin
      pprod_q <= $signed({1'b0, kp_q}) * err_q;
    end
    if (ctrl_i.sum) begin
      torque_q <= sat32(sum_d);
    end
  end

  assign torque_o   = torque_q;
  assign velocity_o = vel_q;

endmodule

`default_nettype wire

/* rtl/lpt_merge.sv */
// Merge stage: leg theta and beta from both angles, and the output register.
`default_nettype none

module lpt_merge import lpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_ctrl_t         ctrl_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] tq_r_i,
  input  logic signed [31:0] tq_l_i,
  input  logic signed [31:0] vel_r_i,
  input  logic signed [31:0] vel_l_i,
  input  logic signed [31:0] angle_r_i,
  input  logic signed [31:0] angle_l_i,
  input  logic        [17:0] offset_i,
  output logic               out_valid_o,
  output logic signed [31:0] torque_right_o,
  output logic signed [31:0] torque_left_o,
  output logic signed [31:0] leg_theta_o,
  output logic signed [31:0] leg_beta_o,
  output logic signed [31:0] velocity_right_o,
  output logic signed [31:0] velocity_left_o
);

  logic signed [32:0] ang_diff;
  logic signed [32:0] ang_sum;
  logic signed [32:0] half_sum;
  logic signed [63:0] theta_wide;
  logic               valid_q;

  // Feedback theta is half the angle difference plus the offset; beta is the mean.
  assign ang_diff   = 33'(angle_l_i) - 33'(angle_r_i);
  assign ang_sum    = 33'(angle_l_i) + 33'(angle_r_i);
  assign half_sum   = ang_sum >>> 1;
  assign theta_wide = 64'(ang_diff >>> 1) + $signed({46'b0, offset_i});

  // Result register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      torque_right_o   <= tq_r_i;
      torque_left_o    <= tq_l_i;
      leg_theta_o      <= sat32(theta_wide);
      leg_beta_o       <= half_sum[31:0];
      velocity_right_o <= vel_r_i;
      velocity_left_o  <= vel_l_i;
    end
  end

  // Valid flag: set on capture, cleared when the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

/* rtl/leg_module_pd_torque.sv */
// Top level of the leg-module PD torque controller: configuration, sequencer and lanes.
`default_nettype none

// Each accepted transaction carries one control tick for both motors of a leg
// module; a right and a left lane compute in parallel and a merge stage forms
// the result. The input stays stalled from acceptance until the result is
// captured, so a new item is not taken while the last one is in the lanes.
// The work runs through a chain of registered steps in each lane: a
// reciprocal quotient estimate, a remainder and one correcting subtraction
// wrap the position error into one turn while the velocity and D products
// run beside them, then come the error, the P product, the torque sum and
// the result capture. The result sits in an output register, so a new item
// is taken while it waits, and the block holds the finished next result
// until that register is free. Velocities use the angles of the previous
// transaction, which are zero after reset.
module leg_module_pd_torque import lpt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_idx_i,
  input  logic        [23:0] cfg_wdata_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] angle_right_i,
  input  logic signed [31:0] angle_left_i,
  input  logic signed [31:0] target_theta_i,
  input  logic signed [31:0] target_beta_i,
  input  logic        [23:0] gain_p_right_i,
  input  logic        [23:0] gain_p_left_i,
  input  logic        [23:0] gain_d_right_i,
  input  logic        [23:0] gain_d_left_i,
  input  logic signed [31:0] feedforward_right_i,
  input  logic signed [31:0] feedforward_left_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] torque_right_o,
  output logic signed [31:0] torque_left_o,
  output logic signed [31:0] leg_theta_o,
  output logic signed [31:0] leg_beta_o,
  output logic signed [31:0] velocity_right_o,
  output logic signed [31:0] velocity_left_o
);

  localparam int unsigned RUN_STEPS = 3;
  localparam int unsigned CNT_W     = $clog2(RUN_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_MULP = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [15:0]        rate_q;
  logic [23:0]        def_p_q;
  logic [23:0]        def_d_q;
  logic [17:0]        offset_q;
  logic signed [31:0] prev_r_q;
  logic signed [31:0] prev_l_q;
  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               in_accept;
  logic               out_free;
  logic               use_default;
  logic signed [31:0] offset_s;
  logic signed [31:0] theta_c;
  logic signed [33:0] ref_r;
  logic signed [33:0] ref_l;
  logic [23:0]        kp_r, kp_l, kd_r, kd_l;
  lane_ctrl_t         ctrl;
  logic signed [31:0] tq_r, tq_l, vel_r, vel_l;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= 16'd1000;
      def_p_q  <= 24'd5898240;
      def_d_q  <= 24'd114688;
      offset_q <= 18'd19445;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SAMPLE_RATE:  rate_q   <= cfg_wdata_i[15:0];
        REG_DEFAULT_P:    def_p_q  <= cfg_wdata_i;
        REG_DEFAULT_D:    def_d_q  <= cfg_wdata_i;
        REG_THETA_OFFSET: offset_q <= cfg_wdata_i[17:0];
        default: ;
      endcase
    end
  end

  // Previous angles, replaced by the new ones on every accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_r_q <= '0;
      prev_l_q <= '0;
    end else if (in_accept) begin
      prev_r_q <= angle_right_i;
      prev_l_q <= angle_left_i;
    end
  end

  // Command preparation: default gains on zero theta, theta raised to the offset.
  always_comb begin
    use_default = (target_theta_i == '0);
    kp_r        = use_default ? def_p_q : gain_p_right_i;
    kp_l        = use_default ? def_p_q : gain_p_left_i;
    kd_r        = use_default ? def_d_q : gain_d_right_i;
    kd_l        = use_default ? def_d_q : gain_d_left_i;
    offset_s    = $signed({14'b0, offset_q});
    theta_c     = (target_theta_i < offset_s) ? offset_s : target_theta_i;
    ref_r       = 34'(target_beta_i) - 34'(theta_c) + 34'(offset_s);
    ref_l       = 34'(target_beta_i) + 34'(theta_c) - 34'(offset_s);
  end

  // Sequencer: three remainder steps beside the velocity and D products, then
  // error, P product, sum and capture.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ctrl         = '0;
    ctrl.load    = in_accept;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_RUN;
          cnt_d   = '0;
        end
      end
      S_RUN: begin
        ctrl.q_mul  = (cnt_q == CNT_W'(0));
        ctrl.v_mul  = (cnt_q == CNT_W'(0));
        ctrl.r_mul  = (cnt_q == CNT_W'(1));
        ctrl.v_sat  = (cnt_q == CNT_W'(1));
        ctrl.r_fold = (cnt_q == CNT_W'(2));
        ctrl.d_mul  = (cnt_q == CNT_W'(2));
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RUN_STEPS - 1)) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        ctrl.fix = 1'b1;
        state_d  = S_MULP;
      end
      S_MULP: begin
        ctrl.p_mul = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        ctrl.sum = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        ctrl.capture = out_free;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Right and left lanes.
  lpt_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_r (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .angle_i    (angle_right_i),
    .prev_i     (prev_r_q),
    .ref_i      (ref_r),
    .kp_i       (kp_r),
    .kd_i       (kd_r),
    .ff_i       (feedforward_right_i),
    .rate_i     (rate_q),
    .torque_o   (tq_r),
    .velocity_o (vel_r)
  );

  lpt_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_l (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .angle_i    (angle_left_i),
    .prev_i     (prev_l_q),
    .ref_i      (ref_l),
    .kp_i       (kp_l),
    .kd_i       (kd_l),
    .ff_i       (feedforward_left_i),
    .rate_i     (rate_q),
    .torque_o   (tq_l),
    .velocity_o (vel_l)
  );

  // Merge and output register.
  lpt_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .out_stall_i      (out_stall_i),
    .tq_r_i           (tq_r),
    .tq_l_i           (tq_l),
    .vel_r_i          (vel_r),
    .vel_l_i          (vel_l),
    .angle_r_i        (prev_r_q),
    .angle_l_i        (prev_l_q),
    .offset_i         (offset_q),
    .out_valid_o      (out_valid_o),
    .torque_right_o   (torque_right_o),
    .torque_left_o    (torque_left_o),
    .leg_theta_o      (leg_theta_o),
    .leg_beta_o       (leg_beta_o),
    .velocity_right_o (velocity_right_o),
    .velocity_left_o  (velocity_left_o)
  );

endmodule

`default_nettype wire

/* rtl/lpt_checker.sv */
// Port-level checker for the leg-module PD torque block and its bind statement.
`default_nettype none

module lpt_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic signed [31:0] torque_right_o
);

  // A result waiting on a stalled output stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its torque value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(torque_right_o))
    else $error("stalled torque changed");

  // The block is busy right after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a transaction");

  // A new result appears only at the end of a busy period.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

endmodule

bind leg_module_pd_torque lpt_checker u_lpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .torque_right_o (torque_right_o)
);

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the leg-module PD torque controller.
module testbench;
  import lpt_pkg::*;

  // Pi and two pi with 16 fraction bits, rounded to nearest.
  localparam longint PI_FX     = 205887;
  localparam longint TWO_PI_FX = 411775;

  localparam int DRAIN_CYCLES  = 60;
  localparam int STALL_LIMIT   = 5000;

  // One control tick for both motors of a leg module.
  typedef struct {
    logic signed [31:0] ang_r;
    logic signed [31:0] ang_l;
    logic signed [31:0] theta;
    logic signed [31:0] beta;
    logic        [23:0] kp_r;
    logic        [23:0] kp_l;
    logic        [23:0] kd_r;
    logic        [23:0] kd_l;
    logic signed [31:0] ff_r;
    logic signed [31:0] ff_l;
  } tick_t;

  // Torques and feedback of one tick.
  typedef struct {
    logic signed [31:0] tq_r;
    logic signed [31:0] tq_l;
    logic signed [31:0] theta;
    logic signed [31:0] beta;
    logic signed [31:0] vel_r;
    logic signed [31:0] vel_l;
  } leg_out_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic        [2:0]  cfg_idx;
  logic        [23:0] cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] angle_right;
  logic signed [31:0] angle_left;
  logic signed [31:0] target_theta;
  logic signed [31:0] target_beta;
  logic        [23:0] gain_p_right;
  logic        [23:0] gain_p_left;
  logic        [23:0] gain_d_right;
  logic        [23:0] gain_d_left;
  logic signed [31:0] feedforward_right;
  logic signed [31:0] feedforward_left;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] torque_right;
  logic signed [31:0] torque_left;
  logic signed [31:0] leg_theta;
  logic signed [31:0] leg_beta;
  logic signed [31:0] velocity_right;
  logic signed [31:0] velocity_left;

  // Shadow copy of the configuration registers.
  logic [15:0] rate_sh;
  logic [23:0] def_p_sh;
  logic [23:0] def_d_sh;
  logic [17:0] off_sh;

  // Previous angles seen by the predictor, and by the stimulus generator.
  longint             prev_ang_r;
  longint             prev_ang_l;
  logic signed [31:0] gen_ang_r;
  logic signed [31:0] gen_ang_l;

  tick_t    tick_q[$];
  leg_out_t torque_expect_q[$];
  tick_t    cur_tick;
  logic     tick_taken;

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int ticks_in;
  int results_out;
  int settings_used;
  int quiet_cycles;
  leg_out_t got_out;
  leg_out_t exp_out;

  leg_module_pd_torque uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .angle_right_i      (angle_right),
    .angle_left_i       (angle_left),
    .target_theta_i     (target_theta),
    .target_beta_i      (target_beta),
    .gain_p_right_i     (gain_p_right),
    .gain_p_left_i      (gain_p_left),
    .gain_d_right_i     (gain_d_right),
    .gain_d_left_i      (gain_d_left),
    .feedforward_right_i(feedforward_right),
    .feedforward_left_i (feedforward_left),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .torque_right_o     (torque_right),
    .torque_left_o      (torque_left),
    .leg_theta_o        (leg_theta),
    .leg_beta_o         (leg_beta),
    .velocity_right_o   (velocity_right),
    .velocity_left_o    (velocity_left)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Clamp a wide value to the signed 32-bit range.
  function automatic longint clamp_wide(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Gain times value, shifted back to 16 fraction bits, half rounds up.
  function automatic longint gain_round(input longint g, input longint x);
    return (g * x + 64'sd32768) >>> 16;
  endfunction

  // Angle error folded into one turn around the feedback angle.
  function automatic longint wrap_turn(input longint target, input longint fb);
    longint m;
    m = (target - fb + PI_FX) % TWO_PI_FX;
    if (m < 0) begin
      m = m + TWO_PI_FX;
    end
    return m - PI_FX;
  endfunction

  // Expected torques and feedback for one tick; advances the stored angles.
  function automatic leg_out_t predict_leg_tick(input tick_t t);
    longint ar, al, th, bt, off, rate;
    longint kpr, kpl, kdr, kdl, vr, vl, er, el, tr, tl;
    leg_out_t r;
    ar   = longint'(t.ang_r);
    al   = longint'(t.ang_l);
    th   = longint'(t.theta);
    bt   = longint'(t.beta);
    kpr  = longint'(t.kp_r);
    kpl  = longint'(t.kp_l);
    kdr  = longint'(t.kd_r);
    kdl  = longint'(t.kd_l);
    off  = longint'(off_sh);
    rate = longint'(rate_sh);

    vr = clamp_wide((ar - prev_ang_r) * rate);
    vl = clamp_wide((al - prev_ang_l) * rate);
    prev_ang_r = ar;
    prev_ang_l = al;

    // A zero theta command selects the default gains on both sides.
    if (th == 0) begin
      kpr = longint'(def_p_sh);
      kpl = longint'(def_p_sh);
      kdr = longint'(def_d_sh);
      kdl = longint'(def_d_sh);
    end
    if (th < off) begin
      th = off;
    end

    er = wrap_turn(bt - th + off, ar);
    el = wrap_turn(bt + th - off, al);
    tr = gain_round(kpr, er) + gain_round(kdr, -vr) + longint'(t.ff_r);
    tl = gain_round(kpl, el) + gain_round(kdl, -vl) + longint'(t.ff_l);

    r.tq_r  = 32'(clamp_wide(tr));
    r.tq_l  = 32'(clamp_wide(tl));
    r.theta = 32'(clamp_wide(((al - ar) >>> 1) + off));
    r.beta  = 32'(clamp_wide((al + ar) >>> 1));
    r.vel_r = 32'(vr);
    r.vel_l = 32'(vl);
    return r;
  endfunction

  function automatic tick_t mk_tick(
    input logic signed [31:0] ar, input logic signed [31:0] al,
    input logic signed [31:0] th, input logic signed [31:0] bt,
    input logic [23:0] kpr, input logic [23:0] kpl,
    input logic [23:0] kdr, input logic [23:0] kdl,
    input logic signed [31:0] ffr, input logic signed [31:0] ffl);
    tick_t t;
    t.ang_r = ar;
    t.ang_l = al;
    t.theta = th;
    t.beta  = bt;
    t.kp_r  = kpr;
    t.kp_l  = kpl;
    t.kd_r  = kdr;
    t.kd_l  = kdl;
    t.ff_r  = ffr;
    t.ff_l  = ffl;
    return t;
  endfunction

  // Mostly plausible motion with random content, some fully random ticks.
  function automatic tick_t make_random_tick();
    tick_t t;
    int    mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      t.ang_r = $urandom;
      t.ang_l = $urandom;
      t.theta = $urandom;
      t.beta  = $urandom;
      t.kp_r  = 24'($urandom);
      t.kp_l  = 24'($urandom);
      t.kd_r  = 24'($urandom);
      t.kd_l  = 24'($urandom);
      t.ff_r  = $urandom;
      t.ff_l  = $urandom;
    end else begin
      if (mode == 4) begin
        t.ang_r = $urandom;
        t.ang_l = $urandom;
      end else begin
        t.ang_r = gen_ang_r + $urandom_range(0, 8192) - 32'd4096;
        t.ang_l = gen_ang_l + $urandom_range(0, 8192) - 32'd4096;
      end
      t.theta = (mode == 2) ? 32'sd0 : $urandom_range(0, 700000) - 32'd50000;
      t.beta  = $urandom_range(0, 2000000) - 32'd1000000;
      if (mode == 3) begin
        t.kp_r = 24'($urandom);
        t.kp_l = 24'($urandom);
        t.kd_r = 24'($urandom);
        t.kd_l = 24'($urandom);
      end else begin
        t.kp_r = 24'($urandom_range(0, 24'h3fffff));
        t.kp_l = 24'($urandom_range(0, 24'h3fffff));
        t.kd_r = 24'($urandom_range(0, 24'h03ffff));
        t.kd_l = 24'($urandom_range(0, 24'h03ffff));
      end
      t.ff_r = $urandom_range(0, 32'h80000) - 32'h40000;
      t.ff_l = $urandom_range(0, 32'h80000) - 32'h40000;
    end
    return t;
  endfunction

  task automatic add_tick(input tick_t t);
    tick_q = {tick_q, t};
    gen_ang_r = t.ang_r;
    gen_ang_l = t.ang_l;
  endtask

  task automatic queue_random_ticks(input int count);
    repeat (count) add_tick(make_random_tick());
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                results_out, name, got, want));
    end
  endtask

  // Register write on the next clock edge; the shadow follows at once since
  // the block is idle whenever this runs.
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SAMPLE_RATE:  rate_sh  = val[15:0];
      REG_DEFAULT_P:    def_p_sh = val;
      REG_DEFAULT_D:    def_d_sh = val;
      REG_THETA_OFFSET: off_sh   = val[17:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] rate, input logic [23:0] p_gain,
                            input logic [23:0] d_gain, input logic [17:0] offset);
    write_reg(REG_SAMPLE_RATE, {8'd0, rate});
    write_reg(REG_DEFAULT_P, p_gain);
    write_reg(REG_DEFAULT_D, d_gain);
    write_reg(REG_THETA_OFFSET, {6'd0, offset});
    settings_used++;
  endtask

  // Hold off until every queued tick is taken and every result is back.
  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || torque_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Driver: present the next tick at the falling edge; a stalled one stays put.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || tick_taken)) begin
      tick_taken = 1'b0;
      if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_tick = tick_q.pop_front();
        in_valid          <= 1'b1;
        angle_right       <= cur_tick.ang_r;
        angle_left        <= cur_tick.ang_l;
        target_theta      <= cur_tick.theta;
        target_beta       <= cur_tick.beta;
        gain_p_right      <= cur_tick.kp_r;
        gain_p_left       <= cur_tick.kp_l;
        gain_d_right      <= cur_tick.kd_r;
        gain_d_left       <= cur_tick.kd_l;
        feedforward_right <= cur_tick.ff_r;
        feedforward_left  <= cur_tick.ff_l;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Input transactions: predict the result of each accepted tick.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) begin
      torque_expect_q = {torque_expect_q, predict_leg_tick(cur_tick)};
      tick_taken = 1'b1;
      ticks_in++;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      got_out.tq_r  = torque_right;
      got_out.tq_l  = torque_left;
      got_out.theta = leg_theta;
      got_out.beta  = leg_beta;
      got_out.vel_r = velocity_right;
      got_out.vel_l = velocity_left;
      if (torque_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, torque_right = %0d", torque_right));
      end else begin
        exp_out = torque_expect_q.pop_front();
        check_field("torque_right", got_out.tq_r, exp_out.tq_r);
        check_field("torque_left", got_out.tq_l, exp_out.tq_l);
        check_field("leg_theta", got_out.theta, exp_out.theta);
        check_field("leg_beta", got_out.beta, exp_out.beta);
        check_field("velocity_right", got_out.vel_r, exp_out.vel_r);
        check_field("velocity_left", got_out.vel_l, exp_out.vel_l);
      end
      results_out++;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_SAMPLE_RATE;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    out_stall         = 1'b0;
    angle_right       = '0;
    angle_left        = '0;
    target_theta      = '0;
    target_beta       = '0;
    gain_p_right      = '0;
    gain_p_left       = '0;
    gain_d_right      = '0;
    gain_d_left       = '0;
    feedforward_right = '0;
    feedforward_left  = '0;
    tick_taken        = 1'b0;
    rate_sh           = 16'd1000;
    def_p_sh          = 24'd5898240;
    def_d_sh          = 24'd114688;
    off_sh            = 18'd19445;
    prev_ang_r        = 0;
    prev_ang_l        = 0;
    gen_ang_r         = '0;
    gen_ang_l         = '0;
    err_count         = 0;
    ticks_in          = 0;
    results_out       = 0;
    settings_used     = 1;
    quiet_cycles      = 0;
    send_idle_pct     = 33;
    recv_idle_pct     = 59;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed ticks under the reset configuration.
    // First tick: velocities against zero angles, zero theta picks the defaults.
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Zero theta with nonzero gains given: the defaults still win.
    add_tick(mk_tick(300, -300, 0, 50000, 24'hffffff, 24'h123456, 24'h00ffff, 24'h7, 5, -5));
    // Theta below the offset is raised; errors of +1 and -1 hit rounding ties.
    add_tick(mk_tick(100, 102, 1, 101, 24'h8000, 24'h8000, 0, 0, 0, 0));
    add_tick(mk_tick(100, 102, 1, 101, 24'h18000, 24'h18000, 0, 0, 0, 0));
    // Error right at the edges of the wrapped turn.
    add_tick(mk_tick(0, 0, -5, 32'(PI_FX), 24'hffffff, 24'hffffff, 0, 0, 0, 0));
    add_tick(mk_tick(0, 0, -5, 32'(PI_FX + 1), 24'hffffff, 24'hffffff, 0, 0, 0, 0));
    add_tick(mk_tick(0, 0, -5, 32'(-PI_FX), 24'h10000, 24'h10000, 0, 0, 0, 0));
    // Theta at, just above and just below the offset.
    add_tick(mk_tick(0, 0, 19445, 0, 24'h10000, 24'h10000, 0, 0, 0, 0));
    add_tick(mk_tick(0, 0, 19446, 0, 24'h10000, 24'h10000, 0, 0, 0, 0));
    add_tick(mk_tick(0, 0, 19444, 0, 24'h10000, 24'h10000, 0, 0, 0, 0));
    // Extreme angles: velocities saturate, and so does feedback theta on the second tick.
    add_tick(mk_tick(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                     24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
                     32'sh7fffffff, 32'sh80000000));
    add_tick(mk_tick(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                     24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
                     32'sh80000000, 32'sh7fffffff));
    // Same angles again: zero velocity, torques from feedforward extremes.
    add_tick(mk_tick(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0,
                     0, 0, 24'hffffff, 24'hffffff, 32'sh7fffffff, 32'sh80000000));
    add_tick(mk_tick(32'sh7fffffff, 32'sh7fffffff, 32'sh00020000, 32'sh7fffffff,
                     24'hffffff, 0, 0, 24'hffffff, 32'sh7fff0000, 32'sh80010000));
    add_tick(mk_tick(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     24'h800000, 24'h000001, 24'h800000, 24'h000001, -1, 1));
    add_tick(mk_tick(-1, -1, -1, -1, 24'hffffff, 24'hffffff, 0, 0, 0, 0));
    add_tick(mk_tick(0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    add_tick(mk_tick(1234567, -7654321, 102943, 411775, 24'h20000, 24'h30000,
                     24'h1000, 24'h2000, 65536, -65536));
    wait_drained();

    // Widest register values.
    set_config(16'hffff, 24'hffffff, 24'hffffff, 18'h3ffff);
    queue_random_ticks(300);
    wait_drained();

    // Sender-heavy idling; zero sample rate and zero defaults.
    send_idle_pct = 59;
    recv_idle_pct = 33;
    set_config(16'd0, 24'd0, 24'd0, 18'd0);
    queue_random_ticks(300);
    wait_drained();

    set_config(16'd1, 24'($urandom), 24'($urandom), 18'($urandom_range(0, 205887)));
    queue_random_ticks(300);
    wait_drained();

    // Full throughput on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(16'($urandom_range(1, 65535)), 24'($urandom), 24'($urandom),
               18'($urandom));
    queue_random_ticks(300);
    wait_drained();

    set_config(16'd1000, 24'd5898240, 24'd114688, 18'd19445);
    queue_random_ticks(50);
    wait_drained();

    $display("summary: %0d ticks accepted, %0d results checked, %0d register settings",
             ticks_in, results_out, settings_used);
    $display("summary: %0d mismatches", err_count);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
